// ----- hw/rtl/slte_pkg.sv -----
// ----------------------------------------------------------------------------
// slte_pkg
// Shared constants and request codes of the sparse list table engine.
// ----------------------------------------------------------------------------
package slte_pkg;

  localparam int unsigned ENTRIES      = 4096;
  localparam int unsigned SECTION_SIZE = 16;
  localparam int unsigned SECTIONS     = ENTRIES / SECTION_SIZE;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned IDX_W        = 13;
  localparam int unsigned TYPE_W       = 3;
  localparam int unsigned ADDR_W       = $clog2(ENTRIES);
  localparam int unsigned OFS_W        = $clog2(SECTION_SIZE);
  localparam int unsigned SEC_W        = ADDR_W - OFS_W;

  typedef enum logic [TYPE_W-1:0] {
    REQ_GET      = 3'd0,
    REQ_PUT      = 3'd1,
    REQ_DELETE   = 3'd2,
    REQ_INSERT   = 3'd3,
    REQ_EXCHANGE = 3'd4,
    REQ_MOVE     = 3'd5,
    REQ_CLEAR    = 3'd6
  } slte_req_e;

endpackage

// ----- hw/rtl/slte_if.sv -----
// ----------------------------------------------------------------------------
// slte_if
// Request and response channels of the sparse list table engine.
// ----------------------------------------------------------------------------
interface slte_req_if ();
  logic                                  valid;
  logic                                  ready;
  logic        [slte_pkg::TYPE_W-1:0]    req_type;
  logic signed [slte_pkg::IDX_W-1:0]     index;
  logic signed [slte_pkg::IDX_W-1:0]     second_index;
  logic        [slte_pkg::VAL_W-1:0]     value;

  modport source (output valid, req_type, index, second_index, value, input ready);
  modport sink   (input valid, req_type, index, second_index, value, output ready);
endinterface

interface slte_rsp_if ();
  logic                                  valid;
  logic                                  ready;
  logic        [slte_pkg::VAL_W-1:0]     read_value;
  logic signed [slte_pkg::IDX_W-1:0]     top_index;
  logic                                  bad_index;

  modport source (output valid, read_value, top_index, bad_index, input ready);
  modport sink   (input valid, read_value, top_index, bad_index, output ready);
endinterface

// ----- hw/rtl/sparse_list_table_engine.sv -----
// ----------------------------------------------------------------------------
// sparse_list_table_engine
// Sparse slot table with high mark, one request at a time, one response each.
// Put, insert and exchange end in a downward mark scan, as does a delete that
// shifts slots; a first write into an empty section adds a section wipe. Delete
// and insert shift the slots between index and mark one at a time; scans go slot by slot.
// Throughput: next transaction taken the cycle after the response loads; a held
// response that is not yet taken stalls the load.
// Reset: section bits cleared, mark -1; memory not wiped (gated by section bits).
// ----------------------------------------------------------------------------
module sparse_list_table_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  slte_req_if.sink    req_i,
  slte_rsp_if.source  rsp_o
);

  localparam int AW = slte_pkg::ADDR_W;
  localparam int OW = slte_pkg::OFS_W;
  localparam int SW = slte_pkg::SEC_W;
  localparam int IW = slte_pkg::IDX_W;
  localparam int VW = slte_pkg::VAL_W;
  localparam int ST_W = 5;

  localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] S_DONE    = 5'd1;
  localparam logic [ST_W-1:0] S_WR      = 5'd2;
  localparam logic [ST_W-1:0] S_SWEEP   = 5'd3;
  localparam logic [ST_W-1:0] S_SCAN_RD = 5'd4;
  localparam logic [ST_W-1:0] S_SCAN_CK = 5'd5;
  localparam logic [ST_W-1:0] S_GET_RD  = 5'd6;
  localparam logic [ST_W-1:0] S_GET_CK  = 5'd7;
  localparam logic [ST_W-1:0] S_PUT_END = 5'd8;
  localparam logic [ST_W-1:0] S_DEL_GO  = 5'd9;
  localparam logic [ST_W-1:0] S_DEL_RD  = 5'd10;
  localparam logic [ST_W-1:0] S_DEL_CK  = 5'd11;
  localparam logic [ST_W-1:0] S_DEL_END = 5'd12;
  localparam logic [ST_W-1:0] S_INS_GO  = 5'd13;
  localparam logic [ST_W-1:0] S_INS_RD  = 5'd14;
  localparam logic [ST_W-1:0] S_INS_CK  = 5'd15;
  localparam logic [ST_W-1:0] S_INS_NX  = 5'd16;
  localparam logic [ST_W-1:0] S_INS_END = 5'd17;
  localparam logic [ST_W-1:0] S_EX_RDA  = 5'd18;
  localparam logic [ST_W-1:0] S_EX_RDB  = 5'd19;
  localparam logic [ST_W-1:0] S_EX_CK   = 5'd20;
  localparam logic [ST_W-1:0] S_EX_W2   = 5'd21;
  localparam logic [ST_W-1:0] S_EX_END  = 5'd22;
  localparam logic [ST_W-1:0] S_MV_RD   = 5'd23;
  localparam logic [ST_W-1:0] S_MV_CK   = 5'd24;
  localparam logic [ST_W-1:0] S_MV_INS  = 5'd25;

  function automatic logic signed [IW-1:0] to_idx(input logic [AW-1:0] x);
    return $signed(IW'({1'b0, x}));
  endfunction

  // control state
  logic [ST_W-1:0]                state_q, state_d;
  logic signed [IW-1:0]           hm_q, hm_d;
  logic [slte_pkg::SECTIONS-1:0]  sec_valid_q, sec_valid_d;
  logic                           out_valid_q, out_valid_d;

  // working registers
  slte_pkg::slte_req_e            op_q, op_d;
  logic [AW-1:0]                  a_q, a_d, b_q, b_d, j_q, j_d;
  logic [AW-1:0]                  w_addr_q, w_addr_d;
  logic [VW-1:0]                  v_q, v_d, w_data_q, w_data_d, rd_q, rd_d;
  logic [OW-1:0]                  k_q, k_d;
  logic signed [IW-1:0]           scan_q, scan_d;
  logic [ST_W-1:0]                w_ret_q, w_ret_d, scan_ret_q, scan_ret_d;
  logic                           bad_q, bad_d;
  logic [VW-1:0]                  out_rd_q, out_rd_d;
  logic signed [IW-1:0]           out_top_q, out_top_d;
  logic                           out_bad_q, out_bad_d;

  // slot memory
  logic [VW-1:0]                  mem [slte_pkg::ENTRIES];
  logic [VW-1:0]                  rdata_q;
  logic                           rvalid_q;
  logic [VW-1:0]                  rmask;
  logic [AW-1:0]                  mem_ra, mem_wa;
  logic [VW-1:0]                  mem_wd;
  logic                           mem_we;
  logic [SW-1:0]                  wsec;
  logic [OW-1:0]                  wofs;

  logic signed [IW-1:0]           a_s, b_s, ab_max, top1;
  logic                           ok_a, ok_b;

  assign a_s    = to_idx(a_q);
  assign b_s    = to_idx(b_q);
  assign ab_max = (a_s > b_s) ? a_s : b_s;
  assign top1   = (hm_q == IW'(slte_pkg::ENTRIES - 1)) ? hm_q : IW'(hm_q + IW'(1));
  assign wsec   = w_addr_q[AW-1:OW];
  assign wofs   = w_addr_q[OW-1:0];
  assign rmask  = rvalid_q ? rdata_q : '0;

  assign ok_a = !req_i.index[IW-1] &&
                (32'(req_i.index[IW-2:0]) < 32'(slte_pkg::ENTRIES));
  assign ok_b = !req_i.second_index[IW-1] &&
                (32'(req_i.second_index[IW-2:0]) < 32'(slte_pkg::ENTRIES));

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_rd_q;
  assign rsp_o.top_index  = out_top_q;
  assign rsp_o.bad_index  = out_bad_q;

  always_comb begin
    case (state_q)
      S_GET_RD, S_MV_RD, S_EX_RDA: mem_ra = a_q;
      S_EX_RDB:                    mem_ra = b_q;
      S_SCAN_RD:                   mem_ra = scan_q[AW-1:0];
      S_DEL_RD:                    mem_ra = AW'(j_q + AW'(1));
      S_INS_RD:                    mem_ra = j_q;
      default:                     mem_ra = a_q;
    endcase
  end

  assign mem_we = ((state_q == S_WR) && sec_valid_q[wsec]) || (state_q == S_SWEEP);
  assign mem_wa = (state_q == S_SWEEP) ? {wsec, k_q} : w_addr_q;
  assign mem_wd = ((state_q == S_SWEEP) && (k_q != wofs)) ? '0 : w_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q  <= mem[mem_ra];
    rvalid_q <= sec_valid_q[mem_ra[AW-1:OW]];
  end

  always_comb begin
    state_d     = state_q;
    hm_d        = hm_q;
    sec_valid_d = sec_valid_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    j_d         = j_q;
    v_d         = v_q;
    k_d         = k_q;
    w_addr_d    = w_addr_q;
    w_data_d    = w_data_q;
    w_ret_d     = w_ret_q;
    scan_d      = scan_q;
    scan_ret_d  = scan_ret_q;
    rd_d        = rd_q;
    bad_d       = bad_q;
    out_rd_d    = out_rd_q;
    out_top_d   = out_top_q;
    out_bad_d   = out_bad_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d  = slte_pkg::slte_req_e'(req_i.req_type);
          a_d   = req_i.index[AW-1:0];
          b_d   = req_i.second_index[AW-1:0];
          v_d   = req_i.value;
          rd_d  = '0;
          bad_d = 1'b0;
          state_d = S_DONE;
          case (slte_pkg::slte_req_e'(req_i.req_type))
            slte_pkg::REQ_GET: begin
              if (ok_a) state_d = S_GET_RD;
              else bad_d = 1'b1;
            end
            slte_pkg::REQ_PUT: begin
              if (ok_a) begin
                w_addr_d = req_i.index[AW-1:0];
                w_data_d = req_i.value;
                w_ret_d  = S_PUT_END;
                state_d  = S_WR;
              end else begin
                bad_d = 1'b1;
              end
            end
            slte_pkg::REQ_DELETE: begin
              if (ok_a) state_d = S_DEL_GO;
            end
            slte_pkg::REQ_INSERT: begin
              if (ok_a) state_d = S_INS_GO;
              else bad_d = 1'b1;
            end
            slte_pkg::REQ_EXCHANGE: begin
              if (ok_a && ok_b) state_d = S_EX_RDA;
              else bad_d = 1'b1;
            end
            slte_pkg::REQ_MOVE: begin
              if (!(ok_a && ok_b)) bad_d = 1'b1;
              else if (req_i.index != req_i.second_index) state_d = S_MV_RD;
            end
            slte_pkg::REQ_CLEAR: begin
              sec_valid_d = '0;
              hm_d        = '1;
            end
            default: ;
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_rd_d    = rd_q;
          out_top_d   = hm_q;
          out_bad_d   = bad_q;
          state_d     = S_IDLE;
        end
      end

      // write with section wipe on first touch
      S_WR: begin
        if (sec_valid_q[wsec]) begin
          state_d = w_ret_q;
        end else begin
          k_d     = '0;
          state_d = S_SWEEP;
        end
      end
      S_SWEEP: begin
        k_d = OW'(k_q + OW'(1));
        if (k_q == OW'(slte_pkg::SECTION_SIZE - 1)) begin
          sec_valid_d[wsec] = 1'b1;
          state_d           = w_ret_q;
        end
      end

      // downward search for the highest nonzero slot
      S_SCAN_RD: begin
        if (scan_q[IW-1]) begin
          hm_d    = scan_q;
          state_d = scan_ret_q;
        end else begin
          state_d = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (rmask != '0) begin
          hm_d    = scan_q;
          state_d = scan_ret_q;
        end else begin
          scan_d  = IW'(scan_q - IW'(1));
          state_d = S_SCAN_RD;
        end
      end

      S_GET_RD: state_d = S_GET_CK;
      S_GET_CK: begin
        rd_d    = rmask;
        state_d = S_DONE;
      end

      S_PUT_END: begin
        scan_d     = (a_s > hm_q) ? a_s : hm_q;
        scan_ret_d = S_DONE;
        state_d    = S_SCAN_RD;
      end

      S_DEL_GO: begin
        if (a_s > hm_q) begin
          state_d = (op_q == slte_pkg::REQ_MOVE) ? S_MV_INS : S_DONE;
        end else begin
          j_d     = a_q;
          state_d = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        if (j_q == hm_q[AW-1:0]) begin
          w_addr_d = j_q;
          w_data_d = '0;
          w_ret_d  = S_DEL_END;
          state_d  = S_WR;
        end else begin
          state_d = S_DEL_CK;
        end
      end
      S_DEL_CK: begin
        w_addr_d = j_q;
        w_data_d = rmask;
        j_d      = AW'(j_q + AW'(1));
        w_ret_d  = S_DEL_RD;
        state_d  = S_WR;
      end
      S_DEL_END: begin
        scan_d     = hm_q;
        scan_ret_d = (op_q == slte_pkg::REQ_MOVE) ? S_MV_INS : S_DONE;
        state_d    = S_SCAN_RD;
      end

      S_INS_GO: begin
        if (a_s > hm_q) begin
          w_addr_d = a_q;
          w_data_d = v_q;
          w_ret_d  = S_INS_END;
          state_d  = S_WR;
        end else begin
          j_d     = hm_q[AW-1:0];
          state_d = S_INS_RD;
        end
      end
      S_INS_RD: state_d = S_INS_CK;
      S_INS_CK: begin
        if (j_q != AW'(slte_pkg::ENTRIES - 1)) begin
          w_addr_d = AW'(j_q + AW'(1));
          w_data_d = rmask;
          w_ret_d  = S_INS_NX;
          state_d  = S_WR;
        end else begin
          state_d = S_INS_NX;
        end
      end
      S_INS_NX: begin
        if (j_q == a_q) begin
          w_addr_d = a_q;
          w_data_d = v_q;
          w_ret_d  = S_INS_END;
          state_d  = S_WR;
        end else begin
          j_d     = AW'(j_q - AW'(1));
          state_d = S_INS_RD;
        end
      end
      S_INS_END: begin
        scan_d     = (a_s > top1) ? a_s : top1;
        scan_ret_d = S_DONE;
        state_d    = S_SCAN_RD;
      end

      S_EX_RDA: state_d = S_EX_RDB;
      S_EX_RDB: begin
        v_d     = rmask;
        state_d = S_EX_CK;
      end
      S_EX_CK: begin
        w_addr_d = a_q;
        w_data_d = rmask;
        w_ret_d  = S_EX_W2;
        state_d  = S_WR;
      end
      S_EX_W2: begin
        w_addr_d = b_q;
        w_data_d = v_q;
        w_ret_d  = S_EX_END;
        state_d  = S_WR;
      end
      S_EX_END: begin
        scan_d     = (ab_max > hm_q) ? ab_max : hm_q;
        scan_ret_d = S_DONE;
        state_d    = S_SCAN_RD;
      end

      S_MV_RD: state_d = S_MV_CK;
      S_MV_CK: begin
        v_d     = rmask;
        state_d = S_DEL_GO;
      end
      S_MV_INS: begin
        a_d     = b_q;
        state_d = S_INS_GO;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hm_q        <= '1;
      sec_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hm_q        <= hm_d;
      sec_valid_q <= sec_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    a_q        <= a_d;
    b_q        <= b_d;
    j_q        <= j_d;
    v_q        <= v_d;
    k_q        <= k_d;
    w_addr_q   <= w_addr_d;
    w_data_q   <= w_data_d;
    w_ret_q    <= w_ret_d;
    scan_q     <= scan_d;
    scan_ret_q <= scan_ret_d;
    rd_q       <= rd_d;
    bad_q      <= bad_d;
    out_rd_q   <= out_rd_d;
    out_top_q  <= out_top_d;
    out_bad_q  <= out_bad_d;
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the sparse list table engine. Sends get, put, delete, insert,
// exchange, move and clear transactions with random gaps on both channels.
// Each response is compared with a local model of the slot table, its section
// flags and its high mark.
// ----------------------------------------------------------------------------
module tb;

  localparam int TW = slte_pkg::TYPE_W;
  localparam int IW = slte_pkg::IDX_W;
  localparam int VW = slte_pkg::VAL_W;
  localparam logic [TW-1:0] REQ_UNUSED = 3'd7;
  localparam int N_SLOTS      = slte_pkg::ENTRIES;
  localparam int SEC_SLOTS    = slte_pkg::SECTION_SIZE;
  localparam int N_SECS       = slte_pkg::SECTIONS;
  localparam int LOW_SPAN     = 48;
  localparam int ITEM_GOAL    = 1300;
  localparam int STALL_MAX    = 10;
  localparam int IDLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [TW-1:0] kind;
    logic [IW-1:0] idx;
    logic [IW-1:0] idx2;
    logic [VW-1:0] val;
  } table_req_t;

  typedef struct packed {
    logic [VW-1:0] rd;
    logic [IW-1:0] top;
    logic          bad;
  } table_rsp_t;

  class slot_table_board;
    logic [VW-1:0] slot_mem [N_SLOTS];
    bit            sec_live [N_SECS];
    int            mark;
    table_rsp_t    pending [$];
    int            errors;
    int            checked;
    int            rejected;
    int            peak_mark;
    int            kind_count [8];

    function new();
      foreach (slot_mem[i]) slot_mem[i] = '0;
      foreach (sec_live[i]) sec_live[i] = 1'b0;
      foreach (kind_count[i]) kind_count[i] = 0;
      mark      = -1;
      peak_mark = -1;
      errors    = 0;
      checked   = 0;
      rejected  = 0;
    endfunction

    function bit in_table(int i);
      return i >= 0 && i < N_SLOTS;
    endfunction

    function logic [VW-1:0] peek(int i);
      if (!in_table(i)) return '0;
      if (!sec_live[i / SEC_SLOTS]) return '0;
      return slot_mem[i];
    endfunction

    function void poke(int i, logic [VW-1:0] v);
      int s;
      s = i / SEC_SLOTS;
      if (!sec_live[s]) begin
        for (int k = 0; k < SEC_SLOTS; k++) slot_mem[s * SEC_SLOTS + k] = '0;
        sec_live[s] = 1'b1;
      end
      slot_mem[i] = v;
    endfunction

    function void settle();
      int i;
      i = mark;
      while (i >= 0 && peek(i) == '0) i--;
      mark = i;
    endfunction

    function void place(int i, logic [VW-1:0] v);
      poke(i, v);
      if (i > mark) mark = i;
      if (v == '0 && mark == i) settle();
    endfunction

    function void remove(int i);
      int top;
      top = mark;
      if (i < 0 || i > top) return;
      for (int j = i; j < top; j++) place(j, peek(j + 1));
      place(top, '0);
    endfunction

    function void open_at(int i, logic [VW-1:0] v);
      bit lost;
      int j;
      lost = 1'b0;
      for (j = mark; j >= i; j--) begin
        if (j + 1 < N_SLOTS) place(j + 1, peek(j));
        else lost = 1'b1;
      end
      place(i, v);
      if (lost) settle();
    endfunction

    function void note_request(table_req_t r);
      int            a;
      int            b;
      logic [VW-1:0] wa;
      logic [VW-1:0] wb;
      table_rsp_t    e;
      a = $signed(r.idx);
      b = $signed(r.idx2);
      e = '0;
      kind_count[r.kind]++;
      case (r.kind)
        slte_pkg::REQ_GET: begin
          if (in_table(a)) e.rd = peek(a);
          else e.bad = 1'b1;
        end
        slte_pkg::REQ_PUT: begin
          if (in_table(a)) place(a, r.val);
          else e.bad = 1'b1;
        end
        slte_pkg::REQ_DELETE: begin
          remove(a);
        end
        slte_pkg::REQ_INSERT: begin
          if (in_table(a)) open_at(a, r.val);
          else e.bad = 1'b1;
        end
        slte_pkg::REQ_EXCHANGE: begin
          if (in_table(a) && in_table(b)) begin
            wa = peek(a);
            wb = peek(b);
            place(a, wb);
            place(b, wa);
          end else begin
            e.bad = 1'b1;
          end
        end
        slte_pkg::REQ_MOVE: begin
          if (in_table(a) && in_table(b)) begin
            if (a != b) begin
              wa = peek(a);
              remove(a);
              open_at(b, wa);
            end
          end else begin
            e.bad = 1'b1;
          end
        end
        slte_pkg::REQ_CLEAR: begin
          foreach (sec_live[i]) sec_live[i] = 1'b0;
          mark = -1;
        end
        default: begin
        end
      endcase
      e.top = mark[IW-1:0];
      if (e.bad) rejected++;
      if (mark > peak_mark) peak_mark = mark;
      pending.push_back(e);
    endfunction

    function void check_response(table_rsp_t got);
      table_rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response: read_value %h top_index %0d bad_index %0b",
                 $time, got.rd, $signed(got.top), got.bad);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.rd !== want.rd) begin
        $display("%0t: read_value expected %h actual %h", $time, want.rd, got.rd);
        errors++;
      end
      if (got.top !== want.top) begin
        $display("%0t: top_index expected %0d actual %0d", $time,
                 $signed(want.top), $signed(got.top));
        errors++;
      end
      if (got.bad !== want.bad) begin
        $display("%0t: bad_index expected %0b actual %0b", $time, want.bad, got.bad);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  bit              steady;
  int              sent;
  int              quiet;
  slot_table_board board;

  slte_req_if req_bus ();
  slte_rsp_if rsp_bus ();

  sparse_list_table_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic table_req_t mk(logic [TW-1:0] k, int a, int b,
                                    logic [VW-1:0] v);
    table_req_t r;
    r.kind = k;
    r.idx  = a[IW-1:0];
    r.idx2 = b[IW-1:0];
    r.val  = v;
    return r;
  endfunction

  function automatic int pick_slot(bit wide);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return -int'($urandom_range(1, 4096));
    if (wide && r < 30) return int'($urandom_range(0, N_SLOTS - 1));
    return int'($urandom_range(0, LOW_SPAN - 1));
  endfunction

  function automatic logic [VW-1:0] pick_word();
    int r;
    r = $urandom_range(0, 19);
    if (r < 5) return '0;
    if (r == 5) return '1;
    return $urandom;
  endfunction

  function automatic table_req_t rand_req();
    int            r;
    int            a;
    int            b;
    logic [TW-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 20) k = slte_pkg::REQ_GET;
    else if (r < 48) k = slte_pkg::REQ_PUT;
    else if (r < 60) k = slte_pkg::REQ_DELETE;
    else if (r < 75) k = slte_pkg::REQ_INSERT;
    else if (r < 84) k = slte_pkg::REQ_EXCHANGE;
    else if (r < 94) k = slte_pkg::REQ_MOVE;
    else if (r < 97) k = slte_pkg::REQ_CLEAR;
    else k = REQ_UNUSED;
    a = pick_slot(k == slte_pkg::REQ_GET || k == slte_pkg::REQ_DELETE);
    if (k == slte_pkg::REQ_EXCHANGE || k == slte_pkg::REQ_MOVE)
      b = ($urandom_range(0, 9) == 0) ? a : pick_slot(1'b0);
    else
      b = int'($urandom_range(0, 8191)) - 4096;
    return mk(k, a, b, pick_word());
  endfunction

  task automatic send(input table_req_t r);
    int gap;
    gap = steady ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= r.kind;
    req_bus.index        <= r.idx;
    req_bus.second_index <= r.idx2;
    req_bus.value        <= r.val;
    do @(posedge clk_i); while (!req_bus.ready);
    board.note_request(r);
    sent++;
  endtask

  // dense run at the last slots: overflow on insert, short scans, moves near the top
  task automatic top_region();
    int base;
    base = N_SLOTS - 6;
    send(mk(slte_pkg::REQ_CLEAR, 0, 0, '0));
    send(mk(slte_pkg::REQ_PUT, base - 1, 0, $urandom | 32'h1));
    for (int k = 0; k < 6; k++)
      if ($urandom_range(0, 3) != 0)
        send(mk(slte_pkg::REQ_PUT, base + k, 0, $urandom | 32'h1));
    send(mk(slte_pkg::REQ_INSERT, base + $urandom_range(0, 5), 0, pick_word()));
    send(mk(slte_pkg::REQ_EXCHANGE, N_SLOTS - 1, base + $urandom_range(0, 4), '0));
    send(mk(slte_pkg::REQ_MOVE, base + $urandom_range(0, 5),
            base + $urandom_range(0, 5), '0));
    send(mk(slte_pkg::REQ_DELETE, base + $urandom_range(0, 5), 0, '0));
    send(mk(slte_pkg::REQ_GET, N_SLOTS - 1, 0, '0));
    send(mk(slte_pkg::REQ_PUT, N_SLOTS - 1, 0, '0));
    send(mk(slte_pkg::REQ_CLEAR, 0, 0, '0));
  endtask

  initial begin : rsp_side
    int         stall;
    table_rsp_t got;
    rsp_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = steady ? 0 : $urandom_range(0, STALL_MAX);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_bus.valid !== 1'b1);
      got.rd  = rsp_bus.read_value;
      got.top = rsp_bus.top_index;
      got.bad = rsp_bus.bad_index;
      board.check_response(got);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet);
      $display("sparse_list_table_engine test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.req_type     <= '0;
    req_bus.index        <= '0;
    req_bus.second_index <= '0;
    req_bus.value        <= '0;
    sent   = 0;
    steady = 1'b0;
    board  = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(mk(slte_pkg::REQ_GET, 0, 0, '0));
    send(mk(slte_pkg::REQ_GET, -1, 0, '0));
    send(mk(slte_pkg::REQ_GET, N_SLOTS - 1, -4096, '1));
    send(mk(slte_pkg::REQ_DELETE, 0, 0, '0));
    send(mk(slte_pkg::REQ_PUT, 0, 0, 32'hFFFF_FFFF));
    send(mk(slte_pkg::REQ_PUT, 5, 0, '0));
    send(mk(slte_pkg::REQ_PUT, 3, 0, 32'h1234_5678));
    send(mk(slte_pkg::REQ_INSERT, 1, 0, 32'h0000_0001));
    send(mk(slte_pkg::REQ_EXCHANGE, 0, 4, '0));
    send(mk(slte_pkg::REQ_MOVE, 4, 0, '0));
    send(mk(slte_pkg::REQ_MOVE, 2, 2, '0));
    send(mk(slte_pkg::REQ_DELETE, 2, 0, '0));
    send(mk(slte_pkg::REQ_DELETE, 100, 0, '0));
    send(mk(slte_pkg::REQ_DELETE, -7, 0, '0));
    send(mk(slte_pkg::REQ_PUT, -4096, 0, 32'hA5A5_A5A5));
    send(mk(slte_pkg::REQ_INSERT, -1, 0, 32'h5A5A_5A5A));
    send(mk(slte_pkg::REQ_EXCHANGE, 1, -5, '0));
    send(mk(slte_pkg::REQ_MOVE, -3, 2, '0));
    send(mk(REQ_UNUSED, 1, 1, 32'hDEAD_BEEF));
    send(mk(slte_pkg::REQ_GET, 1, 0, '0));
    send(mk(slte_pkg::REQ_CLEAR, 0, 0, '0));
    send(mk(slte_pkg::REQ_PUT, N_SLOTS - 3, 0, 32'h0000_0011));
    send(mk(slte_pkg::REQ_PUT, N_SLOTS - 1, 0, 32'h0000_0022));
    send(mk(slte_pkg::REQ_INSERT, N_SLOTS - 2, 0, 32'h0000_0033));
    send(mk(slte_pkg::REQ_CLEAR, 0, 0, '0));

    while (sent < ITEM_GOAL) begin
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 64; n++) send(rand_req());
      steady = 1'b0;
      top_region();
    end
    req_bus.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests: get %0d put %0d delete %0d insert %0d exchange %0d move %0d",
             sent, board.kind_count[slte_pkg::REQ_GET], board.kind_count[slte_pkg::REQ_PUT],
             board.kind_count[slte_pkg::REQ_DELETE], board.kind_count[slte_pkg::REQ_INSERT],
             board.kind_count[slte_pkg::REQ_EXCHANGE], board.kind_count[slte_pkg::REQ_MOVE]);
    $display("clear %0d, unused type %0d; %0d responses checked, %0d rejected, mark peak %0d",
             board.kind_count[slte_pkg::REQ_CLEAR], board.kind_count[REQ_UNUSED],
             board.checked, board.rejected, board.peak_mark);
    if (board.errors == 0) begin
      $display("sparse_list_table_engine test passed");
    end else begin
      $display("sparse_list_table_engine test failed");
    end
    $finish;
  end

endmodule
